// ===== design/ssbp_pkg.sv =====
// Shared types and constants for the soft-start bipolar pulse generator.
`default_nettype none

package ssbp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP        = 2'd1;

  // Register reset values
  localparam longint unsigned HALF_PERIOD_RESET = 64'd10000;
  localparam longint unsigned RAMP_RESET        = 64'd5000000;

  // Output cycle segments, in order
  typedef enum logic [1:0] {
    SEG_A_ON  = 2'd0,
    SEG_A_OFF = 2'd1,
    SEG_B_ON  = 2'd2,
    SEG_B_OFF = 2'd3
  } seg_t;

  // Status of the serial multiply-divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

endpackage

`default_nettype wire

// ===== design/ssbp_if.sv =====
// Handshake interfaces for the tick input, drive output and configuration channels.
`default_nettype none

interface ssbp_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ssbp_out_if;
  logic valid;
  logic ready;
  logic phase_a;
  logic phase_b;
  logic ramp_done;

  modport source (output valid, output phase_a, output phase_b, output ramp_done,
                  input ready);
  modport sink   (input valid, input phase_a, input phase_b, input ramp_done,
                  output ready);
endinterface

interface ssbp_cfg_if #(
  parameter int unsigned DATA_W = 32
);
  logic                           valid;
  logic                           ready;
  logic [ssbp_pkg::CFG_IDX_W-1:0] idx;
  logic [DATA_W-1:0]              data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// ===== design/soft_start_bipolar_pulse_gen.sv =====
// Two-phase inverter drive with linear soft start, one time-base tick per item.
//
// Channels: in_ch carries tick items, out_ch returns one item per input with
// phase_a, phase_b and ramp_done for that tick, cfg_ch writes half_period_ticks
// (index 0) and ramp_ticks (index 1); cfg_ch is always ready; the user must write it
// only while no item is in flight, which the block itself does not enforce.
// Sequence: an item that opens a segment runs the serial multiply-divide
// in ST_CALC when its tick is high and ramp_ticks is nonzero, then ST_FINISH
// registers its result once the output register is free. Any other item,
// and any item with tick low, goes from ST_IDLE straight to ST_FINISH.
// Throughput: one item at a time; in_ch.ready is high only while idle, so the
// rate is set by the divider at segment starts and by the output register
// turnaround elsewhere.
// Reset: the configuration registers take their reset values, the ramp count restarts at zero
// and the cycle restarts at the phase A on segment.
// Stall: a result waits in the output register until taken; a finished item
// holds in its last step until the output register is free.
`default_nettype none

module soft_start_bipolar_pulse_gen #(
  parameter int unsigned HALF_PERIOD_BITS = 20,
  parameter int unsigned RAMP_BITS        = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ssbp_in_if.sink    in_ch,
  ssbp_out_if.source out_ch,
  ssbp_cfg_if.sink   cfg_ch
);
  import ssbp_pkg::*;

  localparam int unsigned HB    = HALF_PERIOD_BITS;
  localparam int unsigned RB    = RAMP_BITS;
  localparam int unsigned CFG_W = (HB > RB) ? HB : RB;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  // Configuration
  logic [HB-1:0]    half_r;
  logic [RB-1:0]    ramp_r;
  logic [CFG_W-1:0] cfg_data;

  // Sequencer and cycle state
  state_t        state_r;
  logic          tick_r;
  logic [HB-1:0] on_r;
  logic [RB-1:0] elapsed_r;
  seg_t          seg_r;
  logic [HB-1:0] pos_r;
  logic [HB-1:0] len_r;
  logic          out_valid_r;
  logic          phase_a_r;
  logic          phase_b_r;
  logic          ramp_done_r;

  // Divider hookup
  logic          md_start;
  md_status_t    md_stat;
  logic [HB-1:0] md_q;
  logic [RB-1:0] e_clamped;

  // Finish step
  logic          in_fire;
  logic          slot_free;
  logic [HB-1:0] off_len;
  logic          found;
  seg_t          try_seg;
  seg_t          sel_seg;
  logic [HB-1:0] try_len;
  logic [HB-1:0] sel_len;
  seg_t          cur_seg;
  logic [HB-1:0] cur_len;
  logic          active;
  logic [HB-1:0] pos_inc;
  logic [HB-1:0] pos_nxt;
  seg_t          seg_nxt;
  logic [RB-1:0] elapsed_nxt;
  logic          phase_a_nxt;
  logic          phase_b_nxt;
  logic          ramp_done_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_data     = CFG_W'(cfg_ch.data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HB'(HALF_PERIOD_RESET);
      ramp_r <= RB'(RAMP_RESET);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_HALF_PERIOD: half_r <= cfg_data[HB-1:0];
        REG_RAMP:        ramp_r <= cfg_data[RB-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !md_stat.busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign e_clamped = (elapsed_r > ramp_r) ? ramp_r : elapsed_r;
  assign md_start  = in_fire && in_ch.tick && (pos_r == '0) && (ramp_r != '0);

  ssbp_muldiv #(
    .HB (HB),
    .RB (RB)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .h      (half_r),
    .e      (e_clamped),
    .r      (ramp_r),
    .status (md_stat),
    .q      (md_q)
  );

  // Skip zero-length segments, at most one full turn of the cycle
  always_comb begin
    off_len = half_r - on_r;
    found   = 1'b0;
    sel_seg = seg_r;
    sel_len = '0;
    for (int k = 0; k < 4; k++) begin
      try_seg = seg_t'(2'(seg_r) + 2'(k));
      try_len = try_seg[0] ? off_len : on_r;
      if (!found && (try_len != '0)) begin
        found   = 1'b1;
        sel_seg = try_seg;
        sel_len = try_len;
      end
    end

    if (pos_r == '0) begin
      active  = found;
      cur_seg = sel_seg;
      cur_len = sel_len;
    end else begin
      active  = 1'b1;
      cur_seg = seg_r;
      cur_len = len_r;
    end

    pos_inc = pos_r + 1'b1;
    seg_nxt = cur_seg;
    pos_nxt = '0;
    if (active) begin
      if (pos_inc >= cur_len) begin
        seg_nxt = seg_t'(2'(cur_seg) + 2'd1);
      end else begin
        pos_nxt = pos_inc;
      end
    end

    elapsed_nxt = (elapsed_r < ramp_r) ? (elapsed_r + 1'b1) : ramp_r;

    if (tick_r) begin
      phase_a_nxt   = active && (cur_seg == SEG_A_ON);
      phase_b_nxt   = active && (cur_seg == SEG_B_ON);
      ramp_done_nxt = (elapsed_nxt >= ramp_r);
    end else begin
      phase_a_nxt   = (seg_r == SEG_A_ON);
      phase_b_nxt   = (seg_r == SEG_B_ON);
      ramp_done_nxt = (elapsed_r >= ramp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      seg_r       <= SEG_A_ON;
      pos_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The finish step refills the slot itself
      if (out_valid_r && out_ch.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            tick_r <= in_ch.tick;
            if (md_start) begin
              state_r <= ST_CALC;
            end else begin
              on_r    <= half_r;
              state_r <= ST_FINISH;
            end
          end
        end
        ST_CALC: begin
          if (md_stat.done) begin
            on_r    <= md_q;
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (slot_free) begin
            out_valid_r <= 1'b1;
            phase_a_r   <= phase_a_nxt;
            phase_b_r   <= phase_b_nxt;
            ramp_done_r <= ramp_done_nxt;
            if (tick_r) begin
              seg_r     <= seg_nxt;
              pos_r     <= pos_nxt;
              len_r     <= cur_len;
              elapsed_r <= elapsed_nxt;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.phase_a   = phase_a_r;
  assign out_ch.phase_b   = phase_b_r;
  assign out_ch.ramp_done = ramp_done_r;

endmodule

`default_nettype wire

// ===== design/ssbp_muldiv.sv =====
// Serial multiply-divide: q = floor(h * e / r) for e <= r, r > 0, a doubling step and an add step per bit of h.
`default_nettype none

module ssbp_muldiv #(
  parameter int unsigned HB = 20,
  parameter int unsigned RB = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [HB-1:0]        h,
  input  wire logic [RB-1:0]        e,
  input  wire logic [RB-1:0]        r,
  output ssbp_pkg::md_status_t      status,
  output logic      [HB-1:0]        q
);
  import ssbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(HB);

  logic             busy_r;
  logic             done_r;
  logic             step_b_r;
  logic [IDX_W-1:0] bit_r;
  logic [HB-1:0]    h_r;
  logic [RB-1:0]    e_r;
  logic [RB-1:0]    r_r;
  logic [RB-1:0]    rem_r;
  logic [HB-1:0]    q_r;

  logic             hbit;
  logic [RB:0]      sum;
  logic [RB:0]      diff;
  logic             ge;
  logic [RB-1:0]    rem_nxt;
  logic [HB-1:0]    q_nxt;

  // One adder for the add step and one compare-subtract shared by the doubling and the add steps
  always_comb begin
    hbit = h_r[bit_r];
    if (step_b_r) begin
      sum = {1'b0, rem_r} + (hbit ? {1'b0, e_r} : {(RB+1){1'b0}});
    end else begin
      sum = {rem_r, 1'b0};
    end
    ge      = (sum >= {1'b0, r_r});
    diff    = sum - {1'b0, r_r};
    rem_nxt = ge ? diff[RB-1:0] : sum[RB-1:0];
    if (step_b_r) begin
      q_nxt = q_r + HB'(ge);
    end else begin
      q_nxt = {q_r[HB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      step_b_r <= 1'b0;
      bit_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        step_b_r <= 1'b0;
        bit_r    <= IDX_W'(HB - 1);
      end else if (busy_r) begin
        step_b_r <= ~step_b_r;
        if (step_b_r) begin
          if (bit_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_r   <= h;
      e_r   <= e;
      r_r   <= r;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign q           = q_r;

endmodule

`default_nettype wire

// ===== design/ssbp_checker.sv =====
// Port-level checks for the soft-start bipolar pulse generator, bound to the top level.
`default_nettype none

module ssbp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic phase_a,
  input wire logic phase_b,
  input wire logic ramp_done
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(phase_a) && $stable(phase_b)
      && $stable(ramp_done))
    else $error("stalled output item changed");

  // Both bridge legs never drive together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(phase_a && phase_b))
    else $error("phase_a and phase_b both on");

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in flight");

endmodule

bind soft_start_bipolar_pulse_gen ssbp_checker u_ssbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .phase_a   (out_ch.phase_a),
  .phase_b   (out_ch.phase_b),
  .ramp_done (out_ch.ramp_done)
);

`default_nettype wire
